/* hdl/plir_pkg.sv */
`default_nettype none

package plir_pkg;

	// List capacity and entry width
	localparam int DEPTH     = 16;
	localparam int ITEM_BITS = 32;

	// Fixed field widths of the request and response beats
	localparam int OP_W   = 3;
	localparam int POS_W  = 5;
	localparam int VAL_W  = 32;
	localparam int LEN_W  = 5;

	// Derived widths
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CMP_W  = (POS_W > CNT_W) ? POS_W : CNT_W;

	// Request opcodes
	typedef enum logic [OP_W-1:0] {
		OP_GET    = 3'd0,
		OP_SET    = 3'd1,
		OP_INSERT = 3'd2,
		OP_REMOVE = 3'd3,
		OP_CLEAR  = 3'd4
	} op_t;

	typedef struct packed {
		logic [OP_W-1:0]  opcode;
		logic [POS_W-1:0] position;
		logic [VAL_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic             ok;
		logic [VAL_W-1:0] read_value;
		logic [LEN_W-1:0] length;
		logic             empty_res;
	} rsp_t;

	// Broadcast from the controller to every cell of the chain
	typedef struct packed {
		logic                 load;       // write data at tgt (set)
		logic                 shift_up;   // insert at tgt, cells above take left neighbor
		logic                 shift_down; // remove at tgt, cells from tgt up take right neighbor
		logic [POS_W-1:0]     tgt;        // zero-based target index
		logic [ITEM_BITS-1:0] data;
	} cell_ctl_t;

endpackage

`default_nettype wire

/* hdl/plir_cell.sv */
`default_nettype none

module plir_cell #(
	parameter int IDX = 0
) (
	input  wire logic                           clk,
	input  wire plir_pkg::cell_ctl_t            ctl,
	input  wire logic [plir_pkg::ITEM_BITS-1:0] left,
	input  wire logic [plir_pkg::ITEM_BITS-1:0] right,
	output logic      [plir_pkg::ITEM_BITS-1:0] data_q
);

	logic at_tgt;
	logic above_tgt;

	// Position of this cell relative to the target
	assign at_tgt    = (ctl.tgt == plir_pkg::POS_W'(IDX));
	assign above_tgt = (plir_pkg::POS_W'(IDX) > ctl.tgt);

	// Entry storage: load, take from a neighbor, or hold
	always_ff @(posedge clk) begin
		if (ctl.shift_up) begin
			if (above_tgt) begin
				data_q <= left;
			end else if (at_tgt) begin
				data_q <= ctl.data;
			end
		end else if (ctl.shift_down) begin
			if (above_tgt || at_tgt) begin
				data_q <= right;
			end
		end else if (ctl.load && at_tgt) begin
			data_q <= ctl.data;
		end
	end

endmodule

`default_nettype wire

/* hdl/plir_rsp_buf.sv */
`default_nettype none

module plir_rsp_buf (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire plir_pkg::rsp_t push_data,
	output logic                full,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output plir_pkg::rsp_t      rsp
);

	logic           out_valid_q;
	logic           skid_valid_q;
	plir_pkg::rsp_t out_q;
	plir_pkg::rsp_t skid_q;
	logic           pop;

	assign pop       = out_valid_q && !rsp_stall;
	assign full      = skid_valid_q;
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	// Valid flags of the output and skid slots
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (!out_valid_q || pop) begin
			out_valid_q <= push;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Payload slots
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (!out_valid_q || pop) begin
			if (push) begin
				out_q <= push_data;
			end
		end else if (push) begin
			skid_q <= push_data;
		end
	end

endmodule

`default_nettype wire

/* hdl/positional_list_insert_remove.sv */
`default_nettype none

// Bounded positional list of up to DEPTH entries, addressed by 1-based position.
// Each request beat (get, set, insert, remove, clear) yields one registered
// response beat once it is accepted, and a new request can be accepted in
// every cycle unless req_stall is high: the entries sit in a row of cells
// that each load, hold, or take their left or right neighbor's entry, so
// insert and remove shift the whole tail at once. A two-beat response buffer
// lets requests keep flowing while a response waits; req_stall rises only
// when both buffer slots are full. Entries are not cleared by reset or by
// clear; only positions holding written data are ever read.
module positional_list_insert_remove (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire plir_pkg::req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output plir_pkg::rsp_t      rsp
);

	localparam int DEPTH = plir_pkg::DEPTH;
	localparam int IB    = plir_pkg::ITEM_BITS;
	localparam int CNT_W = plir_pkg::CNT_W;
	localparam int POS_W = plir_pkg::POS_W;
	localparam int CMP_W = plir_pkg::CMP_W;
	localparam int IDX_W = plir_pkg::IDX_W;

	logic                  in_fire;
	logic                  buf_full;
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      cnt_d;
	logic [POS_W-1:0]      pos_m1;
	logic [CMP_W-1:0]      pos_x;
	logic [CMP_W-1:0]      pos_m1_x;
	logic [CMP_W-1:0]      cnt_x;
	logic                  in_range;
	logic                  ins_ok;
	logic                  list_full;
	logic                  ok;
	logic [IB-1:0]         rd;
	plir_pkg::cell_ctl_t   ctl;
	plir_pkg::rsp_t        rsp_d;
	logic [IB-1:0]         cell_q [DEPTH];

	assign in_fire   = req_valid && !req_stall;
	assign req_stall = buf_full;

	// Range checks on the requested position
	assign pos_m1    = req.position - POS_W'(1);
	assign pos_x     = CMP_W'(req.position);
	assign pos_m1_x  = CMP_W'(pos_m1);
	assign cnt_x     = CMP_W'(count_q);
	assign list_full = (count_q == CNT_W'(DEPTH));
	assign in_range  = (req.position != '0) && (pos_x <= cnt_x);
	assign ins_ok    = (req.position != '0) && (pos_m1_x <= cnt_x) && !list_full;

	// Decode the request into a cell command and the result
	always_comb begin
		ok             = 1'b0;
		rd             = '0;
		cnt_d          = count_q;
		ctl.load       = 1'b0;
		ctl.shift_up   = 1'b0;
		ctl.shift_down = 1'b0;
		ctl.tgt        = pos_m1;
		ctl.data       = IB'(req.value);
		unique case (req.opcode)
			plir_pkg::OP_GET: begin
				if (in_range) begin
					ok = 1'b1;
					rd = cell_q[pos_m1[IDX_W-1:0]];
				end
			end
			plir_pkg::OP_SET: begin
				if (in_range) begin
					ok       = 1'b1;
					ctl.load = in_fire;
				end
			end
			plir_pkg::OP_INSERT: begin
				if (ins_ok) begin
					ok           = 1'b1;
					ctl.shift_up = in_fire;
					cnt_d        = count_q + CNT_W'(1);
				end
			end
			plir_pkg::OP_REMOVE: begin
				if (in_range) begin
					ok             = 1'b1;
					ctl.shift_down = in_fire;
					cnt_d          = count_q - CNT_W'(1);
				end
			end
			plir_pkg::OP_CLEAR: begin
				ok    = 1'b1;
				cnt_d = '0;
			end
			default: ;
		endcase
	end

	// Entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (in_fire) begin
			count_q <= cnt_d;
		end
	end

	// Row of entry cells
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [IB-1:0] left;
		logic [IB-1:0] right;
		if (i == 0) begin : g_first
			assign left = '0;
		end else begin : g_mid_l
			assign left = cell_q[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right = '0;
		end else begin : g_mid_r
			assign right = cell_q[i+1];
		end
		plir_cell #(
			.IDX (i)
		) u_cell (
			.clk    (clk),
			.ctl    (ctl),
			.left   (left),
			.right  (right),
			.data_q (cell_q[i])
		);
	end

	// Response beat
	assign rsp_d.ok         = ok;
	assign rsp_d.read_value = plir_pkg::VAL_W'(rd);
	assign rsp_d.length     = plir_pkg::LEN_W'(cnt_d);
	assign rsp_d.empty_res  = (cnt_d == '0);

	plir_rsp_buf u_rsp_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_fire),
		.push_data (rsp_d),
		.full      (buf_full),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// Checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count above capacity");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && req.opcode == plir_pkg::OP_CLEAR) |=> (count_q == '0))
		else $error("clear did not empty the list");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && req.opcode == plir_pkg::OP_INSERT && ins_ok)
		|=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("insert did not grow the list");

	a_stall_needs_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> rsp_valid)
		else $error("request stalled with no response pending");

endmodule

`default_nettype wire
